/* rtl/bpcl_pkg.sv */
// shared types, constants and helpers for the boost pwm current limiter
package bpcl_pkg;

    localparam int CS_W   = 14;
    localparam int VS_W   = 14;
    localparam int PCT_W  = 7;
    localparam int DUTY_W = 10;
    localparam int TICK_W = 8;
    localparam int FLT_W  = 2;

    typedef logic [CS_W-1:0]   t_cs;
    typedef logic [VS_W-1:0]   t_vs;
    typedef logic [PCT_W-1:0]  t_pct;
    typedef logic [DUTY_W-1:0] t_duty;
    typedef logic [TICK_W-1:0] t_tick;
    typedef logic [FLT_W-1:0]  t_fault;
    // working duty value, wide enough for a decrement below zero
    typedef logic signed [DUTY_W+1:0] t_sduty;

    localparam t_fault FAULT_NONE = 2'd0;
    localparam t_fault FAULT_OV   = 2'd1;
    localparam t_fault FAULT_OC   = 2'd2;

    localparam t_duty DUTY_LIMIT = 10'd950;
    localparam t_tick TICK_STEP  = 8'd255;

    // amps = 8 + cs/124, so amps > n is cs >= (n - 7) * 124
    localparam t_cs CS_OC   = 14'd6572;  // above 60 A
    localparam t_cs CS_CUT4 = 14'd5704;  // above 53 A
    localparam t_cs CS_CUT2 = 14'd5084;  // above 48 A
    localparam t_cs CS_DEC2 = 14'd4712;  // above 45 A
    localparam t_cs CS_DEC1 = 14'd4340;  // above 42 A
    // volts = vs >> 6
    localparam logic [VS_W-7:0] VOLT_MAX = 8'd180;

    localparam t_pct PCT_MAX = 7'd100;
    localparam t_pct PCT_MIN = 7'd40;

    typedef struct packed {
        logic ov;
        logic oc;
        logic cut4;
        logic cut2;
        logic dec2;
        logic dec1;
    } t_sense;

    function automatic t_pct sat_percent(input t_pct p);
        t_pct q;
        q = p;
        if (q > PCT_MAX) begin
            q = PCT_MAX;
        end
        if (q != '0 && q < PCT_MIN) begin
            q = PCT_MIN;
        end
        return q;
    endfunction

    function automatic t_duty target_of(input t_pct p);
        return t_duty'({p, 3'b000}) + t_duty'(p);
    endfunction

endpackage

/* rtl/bpcl_in_if.sv */
// request channel carrying one current and voltage sample pair
interface bpcl_in_if;
    import bpcl_pkg::*;

    logic valid;
    logic ready;
    t_cs  current_sample;
    t_vs  voltage_sample;

    modport source (output valid, output current_sample, output voltage_sample, input ready);
    modport sink   (input valid, input current_sample, input voltage_sample, output ready);
endinterface

/* rtl/bpcl_out_if.sv */
// result channel carrying the duty and status for one period
interface bpcl_out_if;
    import bpcl_pkg::*;

    logic   valid;
    logic   ready;
    t_duty  duty;
    logic   gate_on;
    logic   supply_on;
    t_fault fault;

    modport source (output valid, output duty, output gate_on, output supply_on,
                    output fault, input ready);
    modport sink   (input valid, input duty, input gate_on, input supply_on,
                    input fault, output ready);
endinterface

/* rtl/boost_pwm_current_limiter_unit.sv */
// top level of the boost pwm current limiter
// throughput: one request per cycle; the input register and the result register
// each move on when the next stage has room, so a stalled result blocks intake
// only once both registers hold a request
// reset (synchronous, active low) clears power, duty, tick count and fault latch
// and empties both registers
module boost_pwm_current_limiter_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  bpcl_pkg::t_pct  i_cfg_data,
    bpcl_in_if.sink         i_req,
    bpcl_out_if.source      o_res
);
    import bpcl_pkg::*;

    logic   stg_valid;
    logic   stg_ready;
    t_sense stg;

    bpcl_sense u_sense (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_stg_ready (stg_ready),
        .o_stg_valid (stg_valid),
        .o_stg       (stg)
    );

    bpcl_duty u_duty (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_stg_valid (stg_valid),
        .i_stg       (stg),
        .o_stg_ready (stg_ready),
        .o_res       (o_res)
    );

endmodule

/* rtl/bpcl_sense.sv */
// input register and threshold decode of the current and voltage samples
module bpcl_sense (
    input  logic            i_clk,
    input  logic            i_rst_n,
    bpcl_in_if.sink         i_req,
    input  logic            i_stg_ready,
    output logic            o_stg_valid,
    output bpcl_pkg::t_sense o_stg
);
    import bpcl_pkg::*;

    logic   r_valid;
    logic   n_valid;
    t_sense r_sense;
    t_sense n_sense;
    logic   accept;

    assign i_req.ready = !r_valid || i_stg_ready;
    assign accept      = i_req.valid && i_req.ready;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_stg_ready) begin
            n_valid = 1'b0;
        end
    end

    always_comb begin
        n_sense.ov   = i_req.voltage_sample[VS_W-1:6] > VOLT_MAX;
        n_sense.oc   = i_req.current_sample >= CS_OC;
        n_sense.cut4 = i_req.current_sample >= CS_CUT4;
        n_sense.cut2 = i_req.current_sample >= CS_CUT2;
        n_sense.dec2 = i_req.current_sample >= CS_DEC2;
        n_sense.dec1 = i_req.current_sample >= CS_DEC1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sense <= n_sense;
        end
    end

    assign o_stg_valid = r_valid;
    assign o_stg       = r_sense;

endmodule

/* rtl/bpcl_duty.sv */
// duty state, fault latch, ramp and limit logic with the result register
module bpcl_duty (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  bpcl_pkg::t_pct      i_cfg_data,
    input  logic                i_stg_valid,
    input  bpcl_pkg::t_sense    i_stg,
    output logic                o_stg_ready,
    bpcl_out_if.source          o_res
);
    import bpcl_pkg::*;

    t_pct   r_pct;
    t_duty  r_duty_level;
    t_duty  n_duty_level;
    t_tick  r_tick;
    t_tick  n_tick;
    t_fault r_fault;
    t_fault n_fault;
    logic   r_out_valid;
    logic   n_out_valid;
    t_duty  r_out_duty;
    logic   r_out_gate;
    logic   r_out_supply;
    t_fault r_out_fault;

    logic   take;
    t_duty  target;
    t_sduty d_cur;
    t_sduty d_adj;
    t_sduty d_tgt;
    t_sduty d_lim;

    assign o_stg_ready = !r_out_valid || o_res.ready;
    assign take        = i_stg_valid && o_stg_ready;
    assign target      = target_of(r_pct);

    always_comb begin
        d_cur = t_sduty'({2'b00, r_duty_level});
        d_tgt = t_sduty'({2'b00, target});
        d_lim = t_sduty'({2'b00, DUTY_LIMIT});
        n_tick  = r_tick;
        n_fault = r_fault;
        if (r_fault == FAULT_NONE) begin
            n_tick = r_tick + 1'b1;
            if (i_stg.ov) begin
                n_fault = FAULT_OV;
            end else if (i_stg.oc) begin
                n_fault = FAULT_OC;
            end
        end

        // graded cut ladder, else slow ramp toward target
        d_adj = d_cur;
        if (i_stg.cut4) begin
            d_adj = d_cur >>> 2;
        end else if (i_stg.cut2) begin
            d_adj = d_cur >>> 1;
        end else if (i_stg.dec2) begin
            d_adj = d_cur - t_sduty'(2);
        end else if (i_stg.dec1) begin
            d_adj = d_cur - t_sduty'(1);
        end else if (d_cur < d_tgt && n_tick == TICK_STEP) begin
            d_adj = d_cur + t_sduty'(1);
        end

        if (d_adj > d_tgt) begin
            d_adj = d_tgt;
        end
        if (d_adj > d_lim) begin
            d_adj = d_lim;
        end else if (d_adj < t_sduty'(0)) begin
            d_adj = t_sduty'(0);
        end

        if (n_fault != FAULT_NONE) begin
            n_duty_level = '0;
        end else begin
            n_duty_level = d_adj[DUTY_W-1:0];
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (take) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pct        <= '0;
            r_duty_level <= '0;
            r_tick       <= '0;
            r_fault      <= FAULT_NONE;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                // a power change restarts the ramp from zero
                r_pct        <= sat_percent(i_cfg_data);
                r_duty_level <= '0;
            end else if (take) begin
                r_duty_level <= n_duty_level;
                r_tick       <= n_tick;
                r_fault      <= n_fault;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_duty   <= n_duty_level;
            r_out_gate   <= (r_pct != '0) && (n_fault == FAULT_NONE);
            r_out_supply <= r_pct != '0;
            r_out_fault  <= n_fault;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.duty      = r_out_duty;
    assign o_res.gate_on   = r_out_gate;
    assign o_res.supply_on = r_out_supply;
    assign o_res.fault     = r_out_fault;

    a_fault_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fault != FAULT_NONE |=> r_fault == $past(r_fault))
        else $error("fault latch changed after being set");

    a_fault_zero_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fault != FAULT_NONE |-> r_duty_level == '0)
        else $error("duty nonzero while fault latched");

    a_duty_le_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_duty_level <= target && r_duty_level <= DUTY_LIMIT)
        else $error("duty level above target or limit");

    a_fault_gate_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_fault != FAULT_NONE |-> !r_out_gate && r_out_duty == '0)
        else $error("gate on or duty nonzero in a faulted result");

endmodule

/* test/tb_boost_pwm_current_limiter_unit.sv */
// testbench for the boost pwm current limiter: directed and random periods against a predictor
module tb_boost_pwm_current_limiter_unit;
    import bpcl_pkg::*;

    // sample values at the edges of the current bands and the voltage limit
    localparam int CS_QUIET_TOP = 4339;   // 42 A, no cut
    localparam int CS_DEC1_LOW  = 4340;   // 43 A
    localparam int CS_DEC2_LOW  = 4712;   // 46 A
    localparam int CS_CUT2_LOW  = 5084;   // 49 A
    localparam int CS_CUT4_LOW  = 5704;   // 54 A
    localparam int CS_SAFE_TOP  = 6571;   // 60 A, still no fault
    localparam int CS_TRIP_LOW  = 6572;   // 61 A
    localparam int VS_SAFE_TOP  = 11583;  // 180 V
    localparam int VS_TRIP_LOW  = 11584;  // 181 V
    localparam int SAMPLE_TOP   = 16383;

    typedef struct packed {
        t_duty  duty;
        logic   gate_on;
        logic   supply_on;
        t_fault fault;
    } t_period_status;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    t_pct i_cfg_data;

    bpcl_in_if  req_if ();
    bpcl_out_if res_if ();

    boost_pwm_current_limiter_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_res      (res_if)
    );

    // predictor state
    t_pct   power_pct;
    int     duty_level;
    t_tick  tick_count;
    t_fault fault_latch;

    t_period_status expected_periods[$];
    t_period_status oldest_period;
    int             mismatch_count;
    bit             no_idling;
    int             stall_left;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idling || r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic t_period_status predict_period(input t_cs cs, input t_vs vs);
        int unsigned amps;
        int unsigned volts;
        int target;
        int level;
        t_period_status st;
        amps   = 8 + int'(cs) / 124;
        volts  = int'(vs) >> 6;
        target = 9 * int'(power_pct);
        level  = duty_level;
        if (fault_latch == FAULT_NONE) begin
            tick_count = tick_count + 8'd1;
            // overvoltage wins when both limits are exceeded
            if (volts > 180) begin
                fault_latch = FAULT_OV;
            end else if (amps > 60) begin
                fault_latch = FAULT_OC;
            end
        end
        if (fault_latch != FAULT_NONE) begin
            duty_level = 0;
        end else begin
            if (amps > 53) begin
                level = level >> 2;
            end else if (amps > 48) begin
                level = level >> 1;
            end else if (amps > 45) begin
                level = level - 2;
            end else if (amps > 42) begin
                level = level - 1;
            end else if (level < target && tick_count == 8'd255) begin
                level = level + 1;
            end
            if (level > target) begin
                level = target;
            end
            if (level > 950) begin
                level = 950;
            end else if (level < 0) begin
                level = 0;
            end
            duty_level = level;
        end
        st.duty      = t_duty'(duty_level);
        st.gate_on   = (power_pct != '0) && (fault_latch == FAULT_NONE);
        st.supply_on = (power_pct != '0);
        st.fault     = fault_latch;
        return st;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got %0d, wanted %0d (t=%0t)", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_samples(input int cs, input int vs);
        int gap;
        req_if.valid          = 1'b1;
        req_if.current_sample = t_cs'(cs);
        req_if.voltage_sample = t_vs'(vs);
        do begin
            @(posedge i_clk);
        end while (!req_if.ready);
        expected_periods.push_back(predict_period(t_cs'(cs), t_vs'(vs)));
        @(negedge i_clk);
        gap = pick_gap();
        if (gap != 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // register writes only once the block has drained
    task automatic write_power(input int raw);
        t_pct p;
        req_if.valid = 1'b0;
        while (expected_periods.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = t_pct'(raw);
        p = t_pct'(raw);
        if (p > 7'd100) begin
            p = 7'd100;
        end
        if (p != '0 && p < 7'd40) begin
            p = 7'd40;
        end
        power_pct  = p;
        duty_level = 0;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic send_quiet(input int count);
        repeat (count) begin
            send_samples($urandom_range(0, CS_QUIET_TOP), $urandom_range(0, VS_SAFE_TOP));
        end
    endtask

    task automatic test_band_edges();
        send_samples(0, 0);
        send_samples(CS_QUIET_TOP, VS_SAFE_TOP);
        write_power(100);
        send_samples(CS_DEC1_LOW, 0);
        send_samples(CS_DEC2_LOW - 1, 64);
        send_samples(CS_DEC2_LOW, VS_SAFE_TOP);
        send_samples(CS_CUT2_LOW - 1, 0);
        send_samples(CS_CUT2_LOW, 63);
        send_samples(CS_CUT4_LOW - 1, 0);
        send_samples(CS_CUT4_LOW, 0);
        send_samples(CS_SAFE_TOP, VS_SAFE_TOP);
        send_samples(0, VS_SAFE_TOP);
    endtask

    task automatic test_power_settings();
        int settings[8];
        settings = '{127, 0, 1, 39, 40, 100, 101, 55};
        foreach (settings[k]) begin
            write_power(settings[k]);
            send_quiet(3);
        end
    endtask

    // quiet run long enough for the tick count to reach a ramp step
    task automatic test_ramp();
        write_power(100);
        no_idling = 1'b1;
        send_quiet(140);
        no_idling = 1'b0;
        send_quiet(140);
    endtask

    task automatic test_current_cuts();
        send_samples(CS_DEC1_LOW, 100);
        send_samples(CS_DEC2_LOW, 100);
        send_quiet(10);
        send_samples(CS_CUT2_LOW, 100);
        send_quiet(10);
        send_samples(CS_CUT4_LOW + 500, 100);
        send_samples(CS_DEC1_LOW + 100, 100);
    endtask

    task automatic test_random_periods();
        int r;
        for (int phase = 0; phase < 5; phase++) begin
            // first phase keeps the duty built up by the ramp
            if (phase != 0) begin
                r = $urandom_range(0, 9);
                write_power(r == 0 ? 0 : (r == 1 ? 127 : $urandom_range(0, 127)));
            end
            repeat (20) begin
                r = $urandom_range(0, 99);
                if (r < 80) begin
                    send_samples($urandom_range(0, CS_QUIET_TOP),
                                 r < 5 ? VS_SAFE_TOP : $urandom_range(0, VS_SAFE_TOP));
                end else begin
                    send_samples($urandom_range(CS_DEC1_LOW, CS_SAFE_TOP),
                                 $urandom_range(0, VS_SAFE_TOP));
                end
            end
        end
    endtask

    // the latch holds until reset, so this runs last and trips only one kind
    task automatic test_fault_latch();
        int kind;
        write_power(70);
        send_quiet(5);
        kind = $urandom_range(0, 2);
        case (kind)
            0: begin
                send_samples($urandom_range(0, CS_QUIET_TOP), VS_TRIP_LOW);
            end
            1: begin
                send_samples(CS_TRIP_LOW, $urandom_range(0, VS_SAFE_TOP));
            end
            default: begin
                send_samples(SAMPLE_TOP, SAMPLE_TOP);
            end
        endcase
        send_samples(0, 0);
        send_samples(SAMPLE_TOP, SAMPLE_TOP);
        repeat (30) begin
            send_samples($urandom_range(0, SAMPLE_TOP), $urandom_range(0, SAMPLE_TOP));
        end
        write_power(0);
        repeat (15) begin
            send_samples($urandom_range(0, SAMPLE_TOP), $urandom_range(0, SAMPLE_TOP));
        end
        write_power(127);
        repeat (15) begin
            send_samples($urandom_range(0, SAMPLE_TOP), $urandom_range(0, SAMPLE_TOP));
        end
    endtask

    // receiver side: random back-pressure
    initial begin
        res_if.ready = 1'b0;
        stall_left   = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                res_if.ready = 1'b0;
                stall_left--;
            end else begin
                res_if.ready = 1'b1;
                stall_left   = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_periods.size() == 0) begin
                report_mismatch("unexpected result, duty", res_if.duty, 0);
            end else begin
                oldest_period = expected_periods.pop_front();
                if (res_if.duty !== oldest_period.duty) begin
                    report_mismatch("duty", res_if.duty, oldest_period.duty);
                end
                if (res_if.gate_on !== oldest_period.gate_on) begin
                    report_mismatch("gate_on", res_if.gate_on, oldest_period.gate_on);
                end
                if (res_if.supply_on !== oldest_period.supply_on) begin
                    report_mismatch("supply_on", res_if.supply_on, oldest_period.supply_on);
                end
                if (res_if.fault !== oldest_period.fault) begin
                    report_mismatch("fault", res_if.fault, oldest_period.fault);
                end
            end
        end
    end

    initial begin
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_data            = '0;
        req_if.valid          = 1'b0;
        req_if.current_sample = '0;
        req_if.voltage_sample = '0;
        power_pct             = '0;
        duty_level            = 0;
        tick_count            = '0;
        fault_latch           = FAULT_NONE;
        mismatch_count        = 0;
        no_idling             = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_band_edges();
        test_power_settings();
        test_ramp();
        test_current_cuts();
        test_random_periods();
        test_fault_latch();

        req_if.valid = 1'b0;
        while (expected_periods.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
